// ===== rtl/bsph_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounding sphere block.
// No dependencies; imported by every other file of the block.
package bsph_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DW = 64;     // datapath word
    localparam int WW = 128;    // double word for squares and sums of squares
    localparam int CW = 32;     // center width, signed
    localparam int RW = 33;     // radius width, unsigned
    localparam int OFF_LIM_BIT = 40;   // center step is clamped to 2^40

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_END    = 2'd2;
    localparam logic [1:0] MODE_SECOND = 2'd3;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_FIRST,
        OP_SPAN_MUL,
        OP_ACC_ADD,
        OP_SPAN_PICK,
        OP_DEGEN,
        OP_SET_CENTER,
        OP_RAD_MUL,
        OP_SQRT_START,
        OP_SET_RAD,
        OP_PT_MUL,
        OP_GROW,
        OP_RSQ_MUL,
        OP_SET_RSQ,
        OP_OFF_MUL,
        OP_DIV_START,
        OP_CENTER_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
        logic [1:0] pair;
    } bsph_cmd_t;

    typedef struct packed {
        logic has_points;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic best_zero;
        logic outside;
        logic dist_zero;
    } bsph_stat_t;

endpackage

// ===== rtl/bsph_mul.sv =====
`timescale 1ns / 1ps
// Iterative 64x64 -> 128 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on bsph_pkg.
module bsph_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bsph_pkg::DW-1:0]  a,
    input  logic [bsph_pkg::DW-1:0]  b,
    output logic [bsph_pkg::WW-1:0]  prod,
    output logic                     done
);
    import bsph_pkg::*;

    localparam int HW = DW / 2;

    logic [DW-1:0] a_reg, b_reg;
    logic [DW-1:0] pp_reg;
    logic [1:0]    pp_sh_reg;
    logic [WW-1:0] acc_reg;
    logic [2:0]    cnt_reg;
    logic          run_reg, done_reg;
    logic [HW-1:0] a_h, b_h;

    assign a_h = cnt_reg[0] ? a_reg[DW-1:HW] : a_reg[HW-1:0];
    assign b_h = cnt_reg[1] ? b_reg[DW-1:HW] : b_reg[HW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg    <= DW'(a_h) * DW'(b_h);
                pp_sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + (WW'(pp_reg) << (HW * int'(pp_sh_reg)));
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/bsph_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit floor square root of a 128-bit value, one root bit per cycle.
// Depends on bsph_pkg.
module bsph_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bsph_pkg::WW-1:0]  radicand,
    output logic [bsph_pkg::DW-1:0]  root,
    output logic                     done
);
    import bsph_pkg::*;

    localparam int CNT_W = $clog2(DW);
    localparam int REM_W = DW + 2;

    logic [WW-1:0]    val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [REM_W+1:0] rem2, trial;
    logic             ge;

    assign rem2  = {rem_reg, val_reg[WW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {CNT_W{1'b1}})
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            val_reg  <= val_reg << 2;
            rem_reg  <= ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
            root_reg <= {root_reg[DW-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/bsph_div.sv =====
`timescale 1ns / 1ps
// Restoring 128/64 unsigned divider, one quotient bit per cycle, overflow flag.
// Depends on bsph_pkg.
module bsph_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bsph_pkg::WW-1:0]  num,
    input  logic [bsph_pkg::DW-1:0]  den,
    output logic [bsph_pkg::DW-1:0]  quot,
    output logic                     ovf,
    output logic                     done
);
    import bsph_pkg::*;

    localparam int CNT_W = $clog2(WW);

    logic [WW-1:0]    num_reg;
    logic [DW-1:0]    den_reg, rem_reg, quot_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [DW:0]      rem2;
    logic             ge;

    assign rem2 = {rem_reg, num_reg[WW-1]};
    assign ge   = rem2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {CNT_W{1'b1}})
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (run_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= ge ? DW'(rem2 - {1'b0, den_reg}) : rem2[DW-1:0];
            quot_reg <= {quot_reg[DW-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[DW-1];
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

// ===== rtl/bsph_dp.sv =====
`timescale 1ns / 1ps
// Datapath: extreme points, sphere registers, accumulator and the shared
// multiplier, square root and divider. Depends on bsph_pkg, bsph_mul, bsph_sqrt, bsph_div.
module bsph_dp #(
    parameter int COORD_BITS = bsph_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bsph_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bsph_pkg::bsph_cmd_t             cmd,
    output bsph_pkg::bsph_stat_t            stat,
    input  logic signed [COORD_BITS-1:0]    point_x,
    input  logic signed [COORD_BITS-1:0]    point_y,
    input  logic signed [COORD_BITS-1:0]    point_z,
    output logic signed [bsph_pkg::CW-1:0]  center_x,
    output logic signed [bsph_pkg::CW-1:0]  center_y,
    output logic signed [bsph_pkg::CW-1:0]  center_z,
    output logic [bsph_pkg::RW-1:0]         sphere_radius,
    output logic                            sphere_valid
);
    import bsph_pkg::*;

    localparam logic signed [DW-1:0] C_MAX   = DW'(2**(CW-1) - 1);
    localparam logic signed [DW-1:0] C_MIN   = -C_MAX - DW'(1);
    localparam logic [DW-1:0]        RAD_MAX = DW'({RW{1'b1}});
    localparam logic [DW-1:0]        OFF_MAX = DW'(1) << OFF_LIM_BIT;

    function automatic logic [DW-1:0] shr_sat(input logic [WW-1:0] v);
        logic [WW-1:0] s;
        s = v >> FRAC_BITS;
        if (s[WW-1:DW] != '0)
            return '1;
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic signed [CW-1:0] sat_c(input logic signed [DW-1:0] v);
        if (v > C_MAX)
            return C_MAX[CW-1:0];
        if (v < C_MIN)
            return C_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic [RW-1:0] sat_r(input logic [DW-1:0] v);
        return (v > RAD_MAX) ? '1 : v[RW-1:0];
    endfunction

    // sphere state
    logic                  has_points_reg;
    logic signed [CW-1:0]  center_reg [3];
    logic [RW-1:0]         radius_reg;
    logic [DW-1:0]         rsq_reg;

    // working registers
    logic signed [COORD_BITS-1:0] p_reg [3];
    logic signed [COORD_BITS-1:0] ext_lo_reg [3][3];
    logic signed [COORD_BITS-1:0] ext_hi_reg [3][3];
    logic [WW-1:0]  acc_reg;
    logic [DW-1:0]  best_reg;
    logic [1:0]     pick_reg;
    logic [DW-1:0]  dist_reg;
    logic [DW-1:0]  grow_reg;

    // operand selection
    logic [1:0]                   pair_sel;
    logic signed [COORD_BITS-1:0] lo_ax, hi_ax, p_ax;
    logic signed [DW-1:0]         c_ax, diff_pt, diff_rad, diff_span, c_upd;
    logic [DW-1:0]                off, r_sum;

    logic [DW-1:0] mul_a, mul_b;
    logic          mul_start, mul_done;
    logic [WW-1:0] mul_prod;
    logic [DW-1:0] sq_root;
    logic          sq_done;
    logic [DW-1:0] div_quot;
    logic          div_ovf, div_done;

    always_comb
    begin
        pair_sel  = (cmd.op == OP_SPAN_MUL) ? cmd.pair : pick_reg;
        lo_ax     = ext_lo_reg[pair_sel][cmd.axis];
        hi_ax     = ext_hi_reg[pair_sel][cmd.axis];
        p_ax      = p_reg[cmd.axis];
        c_ax      = DW'(center_reg[cmd.axis]);
        diff_pt   = (DW'(p_ax) <<< FRAC_BITS) - c_ax;
        diff_rad  = (DW'(hi_ax) <<< FRAC_BITS) - c_ax;
        diff_span = DW'(hi_ax) - DW'(lo_ax);

        // center step, clamped
        off = (div_ovf || div_quot > OFF_MAX) ? OFF_MAX : div_quot;
        c_upd = diff_pt[DW-1] ? c_ax - signed'(off) : c_ax + signed'(off);

        // floor((r + d) / 2) without overflow
        r_sum = (DW'(radius_reg) >> 1) + (sq_root >> 1)
              + DW'(radius_reg[0] & sq_root[0]);

        unique case (cmd.op)
            OP_SPAN_MUL:
            begin
                mul_a = mag(diff_span);
                mul_b = mag(diff_span);
            end
            OP_RAD_MUL:
            begin
                mul_a = mag(diff_rad);
                mul_b = mag(diff_rad);
            end
            OP_PT_MUL:
            begin
                mul_a = mag(diff_pt);
                mul_b = mag(diff_pt);
            end
            OP_RSQ_MUL:
            begin
                mul_a = DW'(radius_reg);
                mul_b = DW'(radius_reg);
            end
            OP_OFF_MUL:
            begin
                mul_a = mag(diff_pt);
                mul_b = grow_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (cmd.op == OP_SPAN_MUL) || (cmd.op == OP_RAD_MUL) ||
                       (cmd.op == OP_PT_MUL) || (cmd.op == OP_RSQ_MUL) ||
                       (cmd.op == OP_OFF_MUL);

    bsph_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    bsph_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQRT_START),
        .radicand (acc_reg),
        .root     (sq_root),
        .done     (sq_done)
    );

    bsph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .num   (mul_prod),
        .den   (dist_reg),
        .quot  (div_quot),
        .ovf   (div_ovf),
        .done  (div_done)
    );

    // sphere state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_points_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                center_reg[a] <= '0;
            radius_reg <= '0;
            rsq_reg    <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    has_points_reg <= 1'b0;
                    for (int a = 0; a < 3; a++)
                        center_reg[a] <= '0;
                    radius_reg <= '0;
                    rsq_reg    <= '0;
                end
                OP_FIRST:      has_points_reg <= 1'b1;
                OP_DEGEN:      has_points_reg <= 1'b0;
                OP_SET_CENTER:
                begin
                    for (int a = 0; a < 3; a++)
                        center_reg[a] <= sat_c((DW'(ext_lo_reg[pair_sel][a])
                                              + DW'(ext_hi_reg[pair_sel][a]))
                                              <<< (FRAC_BITS - 1));
                end
                OP_SET_RAD:
                begin
                    radius_reg <= sat_r(sq_root);
                    rsq_reg    <= shr_sat(acc_reg);
                end
                OP_GROW:       radius_reg <= sat_r(r_sum);
                OP_SET_RSQ:    rsq_reg <= shr_sat(mul_prod);
                OP_CENTER_UPD: center_reg[cmd.axis] <= sat_c(c_upd);
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                p_reg[0] <= point_x;
                p_reg[1] <= point_y;
                p_reg[2] <= point_z;
                acc_reg  <= '0;
            end
            OP_FIRST:
            begin
                if (!has_points_reg)
                begin
                    for (int k = 0; k < 3; k++)
                        for (int a = 0; a < 3; a++)
                        begin
                            ext_lo_reg[k][a] <= p_reg[a];
                            ext_hi_reg[k][a] <= p_reg[a];
                        end
                end
                else
                begin
                    // max test only when the min test fails; ties keep the older point
                    for (int a = 0; a < 3; a++)
                    begin
                        if (p_reg[a] < ext_lo_reg[a][a])
                            ext_lo_reg[a] <= p_reg;
                        else if (p_reg[a] > ext_hi_reg[a][a])
                            ext_hi_reg[a] <= p_reg;
                    end
                end
            end
            OP_ACC_ADD:    acc_reg <= acc_reg + mul_prod;
            OP_SPAN_PICK:
            begin
                if (cmd.pair == 2'd0 || acc_reg[DW-1:0] > best_reg)
                begin
                    best_reg <= acc_reg[DW-1:0];
                    pick_reg <= cmd.pair;
                end
                acc_reg <= '0;
            end
            OP_GROW:       dist_reg <= sq_root;
            OP_SET_RSQ:
                grow_reg <= (dist_reg > DW'(radius_reg)) ? dist_reg - DW'(radius_reg) : '0;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.has_points = has_points_reg;
        stat.mul_done   = mul_done;
        stat.sqrt_done  = sq_done;
        stat.div_done   = div_done;
        stat.best_zero  = (best_reg == '0);
        stat.outside    = (shr_sat(acc_reg) > rsq_reg);
        stat.dist_zero  = (dist_reg == '0);
    end

    assign center_x      = has_points_reg ? center_reg[0] : '0;
    assign center_y      = has_points_reg ? center_reg[1] : '0;
    assign center_z      = has_points_reg ? center_reg[2] : '0;
    assign sphere_radius = has_points_reg ? radius_reg : '0;
    assign sphere_valid  = has_points_reg;

endmodule

// ===== rtl/bsph_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences each request through the datapath commands.
// Depends on bsph_pkg.
module bsph_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            mode,
    input  bsph_pkg::bsph_stat_t  stat,
    output bsph_pkg::bsph_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import bsph_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE       = 21'h000001,
        S_CLEAR      = 21'h000002,
        S_FIRST      = 21'h000004,
        S_SPAN_MUL   = 21'h000008,
        S_SPAN_WAIT  = 21'h000010,
        S_SPAN_PICK  = 21'h000020,
        S_END_CHK    = 21'h000040,
        S_RAD_MUL    = 21'h000080,
        S_RAD_WAIT   = 21'h000100,
        S_SQRT       = 21'h000200,
        S_SQRT_WAIT  = 21'h000400,
        S_PT_MUL     = 21'h000800,
        S_PT_WAIT    = 21'h001000,
        S_OUT_CHK    = 21'h002000,
        S_GSQRT_WAIT = 21'h004000,
        S_RSQ_MUL    = 21'h008000,
        S_RSQ_WAIT   = 21'h010000,
        S_OFF_MUL    = 21'h020000,
        S_OFF_WAIT   = 21'h040000,
        S_DIV_WAIT   = 21'h080000,
        S_FINISH     = 21'h100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] pair_reg, pair_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            pair_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        pair_next  = pair_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        cmd.pair   = pair_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op    = OP_LOAD;
                    axis_next = '0;
                    pair_next = '0;
                    unique case (mode)
                        MODE_CLEAR:  state_next = S_CLEAR;
                        MODE_FIRST:  state_next = S_FIRST;
                        MODE_END:    state_next = stat.has_points ? S_SPAN_MUL : S_FINISH;
                        MODE_SECOND: state_next = stat.has_points ? S_PT_MUL : S_FINISH;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_FINISH;
            end
            S_FIRST:
            begin
                cmd.op     = OP_FIRST;
                state_next = S_FINISH;
            end
            S_SPAN_MUL:
            begin
                cmd.op     = OP_SPAN_MUL;
                state_next = S_SPAN_WAIT;
            end
            S_SPAN_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op = OP_ACC_ADD;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = '0;
                        state_next = S_SPAN_PICK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SPAN_MUL;
                    end
                end
            end
            S_SPAN_PICK:
            begin
                cmd.op = OP_SPAN_PICK;
                if (pair_reg == AXIS_LAST)
                    state_next = S_END_CHK;
                else
                begin
                    pair_next  = pair_reg + 2'd1;
                    state_next = S_SPAN_MUL;
                end
            end
            S_END_CHK:
            begin
                if (stat.best_zero)
                begin
                    cmd.op     = OP_DEGEN;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_SET_CENTER;
                    state_next = S_RAD_MUL;
                end
            end
            S_RAD_MUL:
            begin
                cmd.op     = OP_RAD_MUL;
                state_next = S_RAD_WAIT;
            end
            S_RAD_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op = OP_ACC_ADD;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = '0;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_RAD_MUL;
                    end
                end
            end
            S_SQRT:
            begin
                cmd.op     = OP_SQRT_START;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_SET_RAD;
                    state_next = S_FINISH;
                end
            end
            S_PT_MUL:
            begin
                cmd.op     = OP_PT_MUL;
                state_next = S_PT_WAIT;
            end
            S_PT_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op = OP_ACC_ADD;
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = '0;
                        state_next = S_OUT_CHK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_PT_MUL;
                    end
                end
            end
            S_OUT_CHK:
            begin
                if (stat.outside)
                begin
                    cmd.op     = OP_SQRT_START;
                    state_next = S_GSQRT_WAIT;
                end
                else
                    state_next = S_FINISH;
            end
            S_GSQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_GROW;
                    state_next = S_RSQ_MUL;
                end
            end
            S_RSQ_MUL:
            begin
                cmd.op     = OP_RSQ_MUL;
                state_next = S_RSQ_WAIT;
            end
            S_RSQ_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_SET_RSQ;
                    axis_next  = '0;
                    state_next = stat.dist_zero ? S_FINISH : S_OFF_MUL;
                end
            end
            S_OFF_MUL:
            begin
                cmd.op     = OP_OFF_MUL;
                state_next = S_OFF_WAIT;
            end
            S_OFF_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op = OP_CENTER_UPD;
                    if (axis_reg == AXIS_LAST)
                        state_next = S_FINISH;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_OFF_MUL;
                    end
                end
            end
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FINISH);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    a_mul_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mul_done |-> (state_reg == S_SPAN_WAIT || state_reg == S_RAD_WAIT ||
                           state_reg == S_PT_WAIT || state_reg == S_RSQ_WAIT ||
                           state_reg == S_OFF_WAIT))
        else $error("multiplier finished outside a wait state");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (axis_reg != 2'd3 && pair_reg != 2'd3))
        else $error("axis or pair counter out of range");

endmodule

// ===== rtl/bounding_sphere_two_pass_top.sv =====
`timescale 1ns / 1ps
// Work: clear and first-pass point go straight to the result; an end pass runs twelve
//   products and a square root, nine when degenerate; a second-pass point runs three
//   products when inside, and a square root, four more and three divides on growth.
// Requests: one at a time; start is taken again in the cycle after the result.
// Reset: rst_n asynchronous active low; sphere cleared, result strobe cannot be stalled.
// Depends on bsph_pkg, bsph_ctrl, bsph_dp.
module bounding_sphere_two_pass_top #(
    parameter int COORD_BITS = bsph_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bsph_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      mode,
    input  logic signed [COORD_BITS-1:0]    point_x,
    input  logic signed [COORD_BITS-1:0]    point_y,
    input  logic signed [COORD_BITS-1:0]    point_z,
    output logic                            done,
    output logic signed [bsph_pkg::CW-1:0]  center_x,
    output logic signed [bsph_pkg::CW-1:0]  center_y,
    output logic signed [bsph_pkg::CW-1:0]  center_z,
    output logic [bsph_pkg::RW-1:0]         sphere_radius,
    output logic                            sphere_valid
);
    import bsph_pkg::*;

    // Controller walks each request through a short command sequence; the
    // datapath holds all sphere state and the shared arithmetic units.
    bsph_cmd_t  cmd;
    bsph_stat_t stat;

    bsph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Results read straight off the sphere registers; they are stable while
    // done is high because the datapath only moves on a new request.
    bsph_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .sphere_valid  (sphere_valid)
    );

endmodule

// ===== test/bounding_sphere_two_pass_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of bounding_sphere_two_pass_top: directed and random requests,
// results predicted by an in-bench fixed-point bounding sphere model.
// Depends on bsph_pkg and the RTL of the block.
module bounding_sphere_two_pass_top_test;
    import bsph_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [32:0]        rad;
        logic               vld;
    } sphere_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] mode;
    logic signed [CB-1:0] point_x;
    logic signed [CB-1:0] point_y;
    logic signed [CB-1:0] point_z;
    logic done;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [32:0] sphere_radius;
    logic sphere_valid;

    bounding_sphere_two_pass_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .done(done),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .sphere_radius(sphere_radius), .sphere_valid(sphere_valid)
    );

    // predictor state
    longint ext_pt [6][3];
    bit     seen_pts;
    longint ctr [3];
    logic [63:0] rad_q;
    logic [63:0] rad_sq;

    sphere_t pending_spheres[$];
    int      mismatches;
    longint  cycle_cnt;
    bit      no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // result checker: done is a one-cycle strobe, sampled at the rising edge
    always @(posedge clk)
    begin
        sphere_t w;
        if (rst_n && done)
        begin
            if (pending_spheres.size() == 0)
                report_mismatch("unexpected result", 64'd0, 64'd0);
            else
            begin
                w = pending_spheres.pop_front();
                if (center_x !== w.cx)
                    report_mismatch("center_x", 64'(center_x), 64'(w.cx));
                if (center_y !== w.cy)
                    report_mismatch("center_y", 64'(center_y), 64'(w.cy));
                if (center_z !== w.cz)
                    report_mismatch("center_z", 64'(center_z), 64'(w.cz));
                if (sphere_radius !== w.rad)
                    report_mismatch("radius", 64'(sphere_radius), 64'(w.rad));
                if (sphere_valid !== w.vld)
                    report_mismatch("valid", 64'(sphere_valid), 64'(w.vld));
            end
        end
    end

    // ---------------- predictor helpers ----------------
    function automatic logic [127:0] sq_dist(input longint q [3]);
        logic [127:0] s;
        logic [63:0]  d;
        longint df;
        s = '0;
        for (int a = 0; a < 3; a++)
        begin
            df = q[a] - ctr[a];
            d = (df < 0) ? -df : df;
            s += {64'd0, d} * {64'd0, d};
        end
        return s;
    endfunction

    function automatic logic [63:0] drop_frac_sat(input logic [127:0] v);
        if ((v >> (64 + FB)) != 0) return '1;
        return v[FB +: 64];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] clamp_rad(input logic [63:0] r);
        return (r > 64'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : r;
    endfunction

    function automatic longint sext(input logic [CB-1:0] raw);
        return longint'($signed(raw));
    endfunction

    // applies one request to the model and returns the expected sphere
    function automatic sphere_t model_sphere(input logic [1:0] m, input logic [CB-1:0] px,
                                             input logic [CB-1:0] py, input logic [CB-1:0] pz);
        longint p [3];
        longint q [3];
        longint df;
        logic [63:0] best, span, d, dist_q, grow, off;
        logic [127:0] d2, quot;
        int pick;
        sphere_t s;
        p[0] = sext(px); p[1] = sext(py); p[2] = sext(pz);
        case (m)
            MODE_CLEAR:
            begin
                foreach (ext_pt[i, a]) ext_pt[i][a] = 0;
                seen_pts = 1'b0;
                foreach (ctr[a]) ctr[a] = 0;
                rad_q = '0;
                rad_sq = '0;
            end
            MODE_FIRST:
            begin
                if (!seen_pts)
                begin
                    foreach (ext_pt[i, a]) ext_pt[i][a] = p[a];
                    seen_pts = 1'b1;
                end
                else
                    for (int a = 0; a < 3; a++)
                    begin
                        // strict compares: earliest point keeps a tie; max only if min fails
                        if (p[a] < ext_pt[2*a][a]) ext_pt[2*a] = p;
                        else if (p[a] > ext_pt[2*a+1][a]) ext_pt[2*a+1] = p;
                    end
            end
            MODE_END:
            begin
                if (seen_pts)
                begin
                    best = '0;
                    pick = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        span = '0;
                        for (int a = 0; a < 3; a++)
                        begin
                            df = ext_pt[2*k+1][a] - ext_pt[2*k][a];
                            d = (df < 0) ? -df : df;
                            span += d * d;
                        end
                        if (k == 0 || span > best)
                        begin
                            best = span;
                            pick = k;
                        end
                    end
                    if (best == 0)
                        seen_pts = 1'b0;   // degenerate: sphere kept, flag dropped
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            ctr[a] = clamp32((ext_pt[2*pick][a] + ext_pt[2*pick+1][a])
                                             * (64'sd1 <<< (FB - 1)));
                            q[a] = ext_pt[2*pick+1][a] * (64'sd1 <<< FB);
                        end
                        d2 = sq_dist(q);
                        rad_q = clamp_rad(floor_sqrt(d2));
                        rad_sq = drop_frac_sat(d2);
                    end
                end
            end
            default:
            begin
                if (seen_pts)
                begin
                    for (int a = 0; a < 3; a++) q[a] = p[a] * (64'sd1 <<< FB);
                    d2 = sq_dist(q);
                    if (drop_frac_sat(d2) > rad_sq)
                    begin
                        dist_q = floor_sqrt(d2);
                        rad_q = clamp_rad((rad_q >> 1) + (dist_q >> 1)
                                          + (rad_q & dist_q & 64'd1));
                        rad_sq = drop_frac_sat({64'd0, rad_q} * {64'd0, rad_q});
                        grow = (dist_q > rad_q) ? dist_q - rad_q : '0;
                        if (dist_q != 0)
                            for (int a = 0; a < 3; a++)
                            begin
                                df = q[a] - ctr[a];
                                d = (df < 0) ? -df : df;
                                quot = ({64'd0, d} * {64'd0, grow}) / {64'd0, dist_q};
                                off = (quot[127:64] != 0) ? '1 : quot[63:0];
                                if (off > (64'd1 << OFF_LIM_BIT)) off = 64'd1 << OFF_LIM_BIT;
                                ctr[a] = clamp32(df < 0 ? ctr[a] - longint'(off)
                                                        : ctr[a] + longint'(off));
                            end
                    end
                end
            end
        endcase
        s.vld = seen_pts;
        s.cx  = seen_pts ? ctr[0][31:0] : '0;
        s.cy  = seen_pts ? ctr[1][31:0] : '0;
        s.cz  = seen_pts ? ctr[2][31:0] : '0;
        s.rad = seen_pts ? rad_q[32:0] : '0;
        return s;
    endfunction

    // ---------------- stimulus ----------------
    // sends one request, with a random idle gap, and records the expected sphere
    task automatic send_request(input logic [1:0] m, input logic [CB-1:0] px,
                                input logic [CB-1:0] py, input logic [CB-1:0] pz);
        while (!no_gaps && $urandom_range(99) < 21) @(negedge clk);
        mode <= m; point_x <= px; point_y <= py; point_z <= pz;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_spheres.push_back(model_sphere(m, px, py, pz));
        @(negedge clk);
        start <= 1'b0;
        // block stays busy at least this cycle, so the next request loses nothing
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_spheres.size() != 0) @(negedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord(input int spread);
        case ($urandom_range(5))
            0: return CB'($urandom);                  // full range
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return CB'($signed($urandom_range(2*spread)) - spread);
        endcase
    endfunction

    task automatic test_directed();
        send_request(MODE_END, '0, '0, '0);       // end pass with no points
        send_request(MODE_SECOND, CB'(5), CB'(5), CB'(5));   // no points: ignored
        send_request(MODE_FIRST, CB'(3), CB'(3), CB'(3));
        send_request(MODE_FIRST, CB'(3), CB'(3), CB'(3));
        send_request(MODE_END, '0, '0, '0);       // degenerate: all spans zero
        send_request(MODE_SECOND, CB'(1), CB'(1), CB'(1));   // no points after the degenerate end pass: ignored
        send_request(MODE_CLEAR, '0, '0, '0);
        send_request(MODE_FIRST, 16'h8000, 16'h8000, 16'h8000);
        send_request(MODE_FIRST, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(MODE_FIRST, 16'h8000, '0, 16'h7FFF);   // ties keep earlier points
        send_request(MODE_END, '0, '0, '0);
        send_request(MODE_SECOND, '0, '0, '0);    // inside
        send_request(MODE_SECOND, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_request(MODE_SECOND, 16'h8000, 16'h7FFF, 16'h8000);
        send_request(MODE_CLEAR, '0, '0, '0);
        send_request(MODE_FIRST, CB'(10), CB'(-5), CB'(2));
        send_request(MODE_SECOND, CB'(20), CB'(20), CB'(-20));   // before end pass
        send_request(MODE_END, '0, '0, '0);
        send_request(MODE_FIRST, CB'(-7), CB'(4), CB'(100));
        send_request(MODE_END, '0, '0, '0);
        send_request(MODE_SECOND, CB'(200), CB'(-300), CB'(9));
        send_request(MODE_SECOND, CB'(200), CB'(-300), CB'(9));  // now on the sphere
    endtask

    // mostly well-formed clear / first pass / end / second pass sequences
    task automatic test_random_sequences(input int n_items);
        int sent, spread, n, n_sec;
        bit with_end;
        sent = 0;
        while (sent < n_items)
        begin
            spread = $urandom_range(3) == 0 ? 32767 : (1 << $urandom_range(12));
            if ($urandom_range(9) == 0)
            begin
                send_request(2'($urandom), rand_coord(spread), rand_coord(spread),
                             rand_coord(spread));
                sent++;
                continue;
            end
            n = $urandom_range(1, 8);
            with_end = ($urandom_range(7) != 0);
            n_sec = $urandom_range(1, 6);
            send_request(MODE_CLEAR, CB'($urandom), CB'($urandom), CB'($urandom));
            repeat (n) send_request(MODE_FIRST, rand_coord(spread), rand_coord(spread),
                                    rand_coord(spread));
            if (with_end)
                send_request(MODE_END, CB'($urandom), CB'($urandom), CB'($urandom));
            repeat (n_sec)
                send_request(MODE_SECOND, rand_coord(spread), rand_coord(spread),
                             rand_coord(spread));
            sent += 1 + n + int'(with_end) + n_sec;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_CLEAR;
        point_x = '0; point_y = '0; point_z = '0;
        cycle_cnt = 0;
        mismatches = 0;
        no_gaps = 0;
        foreach (ext_pt[i, a]) ext_pt[i][a] = 0;
        seen_pts = 1'b0;
        foreach (ctr[a]) ctr[a] = 0;
        rad_q = '0;
        rad_sq = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        wait_drained();                 // sender holds until all results are in
        test_random_sequences(250);
        no_gaps = 1;                    // back-to-back stretch
        test_random_sequences(100);
        no_gaps = 0;
        test_random_sequences(180);

        wait_drained();
        repeat (600) @(negedge clk);
        if (mismatches == 0 && pending_spheres.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
